[design/cbd_pkg.sv]
`timescale 1ns / 1ps

package cbd_pkg;

    // Decoder phase. The fourth code is unused and decodes as idle.
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ARG     = 2'd1,
        PH_PAYLOAD = 2'd2
    } cbd_phase_t;

    // Token kind, carried on tuser.
    localparam logic [1:0] KIND_HEAD    = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [2:0] MAJ_NEGINT = 3'd1;
    localparam logic [2:0] MAJ_BYTES  = 3'd2;
    localparam logic [2:0] MAJ_TEXT   = 3'd3;

    localparam logic [4:0] AI_ONE_BYTE   = 5'd24;
    localparam logic [4:0] AI_EIGHT_BYTE = 5'd27;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_TUSER_W = 2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  major_type;
        logic [63:0] value;
        logic [7:0]  payload_byte;
        logic        last_payload;
    } cbd_token_t;

endpackage

[design/cbd_decoder.sv]
`timescale 1ns / 1ps

module cbd_decoder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_accept,
    input  logic [7:0]        in_byte,
    output logic              token_valid,
    output cbd_pkg::cbd_token_t token
);
    import cbd_pkg::*;

    cbd_phase_t  phase_reg, phase_next;
    logic [2:0]  major_reg, major_next;
    logic [3:0]  arg_left_reg, arg_left_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] pay_left_reg, pay_left_next;

    logic        finish;
    logic [63:0] fin_arg;
    logic [2:0]  major_eff;
    logic [63:0] acc_shift;
    logic [4:0]  ai;
    logic        last;
    logic        res_valid;

    assign ai        = in_byte[4:0];
    assign acc_shift = {acc_reg[55:0], in_byte};

    always_comb
    begin
        phase_next    = phase_reg;
        major_next    = major_reg;
        arg_left_next = arg_left_reg;
        acc_next      = acc_reg;
        pay_left_next = pay_left_reg;
        res_valid     = 1'b0;
        token         = '0;
        finish        = 1'b0;
        fin_arg       = '0;
        major_eff     = major_reg;
        last          = 1'b0;

        unique case (phase_reg)
            PH_ARG:
            begin
                acc_next      = acc_shift;
                arg_left_next = arg_left_reg - 4'd1;
                if (arg_left_next == 4'd0)
                begin
                    finish  = 1'b1;
                    fin_arg = acc_shift;
                end
            end
            PH_PAYLOAD:
            begin
                last               = (pay_left_reg <= 64'd1);
                res_valid          = 1'b1;
                token.kind         = KIND_PAYLOAD;
                token.major_type   = major_reg;
                token.payload_byte = in_byte;
                token.last_payload = last;
                if (last)
                begin
                    pay_left_next = '0;
                    phase_next    = PH_IDLE;
                end
                else
                begin
                    pay_left_next = pay_left_reg - 64'd1;
                end
            end
            default:
            begin
                // Initial byte of a new item.
                major_eff     = in_byte[7:5];
                major_next    = in_byte[7:5];
                phase_next    = PH_IDLE;
                acc_next      = '0;
                arg_left_next = '0;
                if (ai < AI_ONE_BYTE)
                begin
                    finish  = 1'b1;
                    fin_arg = {59'd0, ai};
                end
                else if (ai <= AI_EIGHT_BYTE)
                begin
                    arg_left_next = 4'd1 << ai[1:0];
                    phase_next    = PH_ARG;
                end
                else
                begin
                    res_valid        = 1'b1;
                    token.kind       = KIND_ERROR;
                    token.major_type = major_eff;
                end
            end
        endcase

        if (finish)
        begin
            res_valid        = 1'b1;
            token.kind       = KIND_HEAD;
            token.major_type = major_eff;
            token.value      = (major_eff == MAJ_NEGINT) ? ~fin_arg : fin_arg;
            acc_next         = '0;
            arg_left_next    = '0;
            if ((major_eff == MAJ_BYTES || major_eff == MAJ_TEXT) && fin_arg != 64'd0)
            begin
                pay_left_next = fin_arg;
                phase_next    = PH_PAYLOAD;
            end
            else
            begin
                pay_left_next = '0;
                phase_next    = PH_IDLE;
            end
        end
    end

    assign token_valid = res_valid & byte_accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            major_reg    <= '0;
            arg_left_reg <= '0;
            acc_reg      <= '0;
            pay_left_reg <= '0;
        end
        else if (byte_accept)
        begin
            phase_reg    <= phase_next;
            major_reg    <= major_next;
            arg_left_reg <= arg_left_next;
            acc_reg      <= acc_next;
            pay_left_reg <= pay_left_next;
        end
    end

endmodule

[design/cbd_skid.sv]
`timescale 1ns / 1ps

module cbd_skid (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  cbd_pkg::cbd_token_t in_data,
    output logic                in_ready,
    output logic                out_valid,
    output cbd_pkg::cbd_token_t out_data,
    input  logic                out_ready
);
    import cbd_pkg::*;

    logic       main_valid_reg, main_valid_next;
    logic       skid_valid_reg, skid_valid_next;
    cbd_token_t main_reg, main_next;
    cbd_token_t skid_reg, skid_next;
    logic       main_free;

    // The skid register catches a token that arrives while the main one stalls.
    assign in_ready  = ~skid_valid_reg;
    assign main_free = out_ready | ~main_valid_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (main_free)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = in_data;
                main_valid_next = in_valid;
            end
        end
        else if (in_valid)
        begin
            skid_next       = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

[design/cbor_token_decoder_top.sv]
`timescale 1ns / 1ps
// CBOR item head decoder.
// The s_axis channel carries the encoded stream, one byte per request in
// s_axis_tdata. The m_axis channel returns tokens: tuser holds the kind
// (head, string payload byte or error), tdata holds the major type, the
// 64-bit argument (ones' complement for negative integers, raw bits for
// floats) and the payload byte, and tlast marks the final byte of a string.
// A head with 1, 2, 4 or 8 argument bytes gives its token on the request
// that carries its last argument byte; argument bytes give no token.
// Throughput is one byte per clock while s_axis_tready is high. The decoder
// state and the token are computed from the accepted byte in the same cycle;
// the token is then registered in the output register, and the decode path
// runs between the decoder state registers and that output register.
// When the receiver stalls, a second register behind the output holds one
// more token, so s_axis_tready drops only once both are full.
// Reset clears the decoder to wait for an initial byte and empties the
// output registers; no clearing pass is needed.
module cbor_token_decoder_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [cbd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [7:0] in_byte
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [2:0] major_type, [66:3] value, [74:67] payload_byte, [79:75] zero
    output logic [cbd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic [cbd_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,  // [1:0] kind
    output logic                             m_axis_tlast   // last_payload
);
    import cbd_pkg::*;

    logic       byte_accept;
    logic       token_valid;
    cbd_token_t token;
    cbd_token_t out_token;

    assign byte_accept = s_axis_tvalid & s_axis_tready;

    cbd_decoder u_decoder (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_accept (byte_accept),
        .in_byte     (s_axis_tdata),
        .token_valid (token_valid),
        .token       (token)
    );

    cbd_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (token_valid),
        .in_data   (token),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (out_token),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {5'd0, out_token.payload_byte, out_token.value,
                           out_token.major_type};
    assign m_axis_tuser = out_token.kind;
    assign m_axis_tlast = out_token.last_payload;

endmodule

[design/cbd_checker.sv]
`timescale 1ns / 1ps

module cbd_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [cbd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [cbd_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    input logic                            m_axis_tlast
);
    import cbd_pkg::*;

    // A stalled token holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("token changed while stalled");

    // Only head, payload and error kinds are produced.
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == KIND_HEAD || m_axis_tuser == KIND_PAYLOAD
                           || m_axis_tuser == KIND_ERROR))
        else $error("bad token kind");

    // Value is zero except on head tokens.
    a_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_HEAD |-> m_axis_tdata[66:3] == 64'd0)
        else $error("value set on non-head token");

    // Payload byte and last marker appear only on payload tokens.
    a_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_PAYLOAD |->
            m_axis_tdata[74:67] == 8'd0 && !m_axis_tlast)
        else $error("payload fields set on non-payload token");

endmodule

bind cbor_token_decoder_top cbd_checker u_cbd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

[verif/cbor_token_decoder_top_test.sv]
`timescale 1ns / 1ps

module cbor_token_decoder_top_test;
    import cbd_pkg::*;

    // Major types and additional info codes that the package leaves out.
    localparam logic [2:0] MAJ_UINT   = 3'd0;
    localparam logic [2:0] MAJ_ARRAY  = 3'd4;
    localparam logic [2:0] MAJ_MAP    = 3'd5;
    localparam logic [2:0] MAJ_TAG    = 3'd6;
    localparam logic [2:0] MAJ_SIMPLE = 3'd7;

    localparam logic [4:0] AI_DIRECT_MAX = 5'd23;
    localparam logic [4:0] AI_TWO_BYTE   = 5'd25;
    localparam logic [4:0] AI_FOUR_BYTE  = 5'd26;
    localparam logic [4:0] AI_RSVD_FIRST = 5'd28;
    localparam logic [4:0] AI_RSVD_MID1  = 5'd29;
    localparam logic [4:0] AI_RSVD_MID2  = 5'd30;
    localparam logic [4:0] AI_INDEF      = 5'd31;

    localparam int RANDOM_BYTES = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 2000000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic [OUT_TUSER_W-1:0]  m_axis_tuser;
    logic                    m_axis_tlast;

    cbor_token_decoder_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Decoder state as this bench expects it to be after every accepted byte.
    cbd_phase_t  pred_phase = PH_IDLE;
    logic [2:0]  pred_major = '0;
    logic [3:0]  arg_left = '0;
    logic [63:0] arg_acc = '0;
    logic [63:0] pay_left = '0;

    cbd_token_t  expected_tokens[$];

    int          error_count = 0;
    int          bytes_sent = 0;
    int          tokens_checked = 0;
    int          heads_seen = 0;
    int          payloads_seen = 0;
    int          errors_seen = 0;
    int          cycle_count = 0;
    int          rx_hold = 0;
    bit          no_idle = 1'b0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Most calls give no gap or a short one, a few give a long one.
    function automatic int gap_len();
        int r;
        if (no_idle)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            return 0;
        end
        else if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] head_byte(input logic [2:0] major, input logic [4:0] ai);
        return {major, ai};
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("mismatch at token %0d, %s: expected %h, got %h",
                 tokens_checked, what, want, got);
        error_count++;
    endtask

    task automatic compare_field(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            report_mismatch(what, want, got);
        end
    endtask

    task push_token(input logic [1:0] kind, input logic [2:0] major, input logic [63:0] value,
                    input logic [7:0] pbyte, input logic last);
        cbd_token_t tok;
        tok.kind         = kind;
        tok.major_type   = major;
        tok.value        = value;
        tok.payload_byte = pbyte;
        tok.last_payload = last;
        expected_tokens.push_back(tok);
    endtask

    // A complete head gives its token and either opens a string payload or
    // returns to idle.
    task finish_head(input logic [63:0] arg);
        push_token(KIND_HEAD, pred_major, (pred_major == MAJ_NEGINT) ? ~arg : arg, '0, 1'b0);
        arg_left = '0;
        arg_acc  = '0;
        if ((pred_major == MAJ_BYTES || pred_major == MAJ_TEXT) && arg != 0)
        begin
            pay_left   = arg;
            pred_phase = PH_PAYLOAD;
        end
        else
        begin
            pay_left   = '0;
            pred_phase = PH_IDLE;
        end
    endtask

    task decode_byte(input logic [7:0] b);
        logic [4:0] ai;
        logic       last;
        ai = b[4:0];
        case (pred_phase)
            PH_ARG:
            begin
                arg_acc  = {arg_acc[55:0], b};
                arg_left = arg_left - 4'd1;
                if (arg_left == 0)
                begin
                    finish_head(arg_acc);
                end
            end
            PH_PAYLOAD:
            begin
                last = (pay_left <= 1);
                push_token(KIND_PAYLOAD, pred_major, '0, b, last);
                if (last)
                begin
                    pay_left   = '0;
                    pred_phase = PH_IDLE;
                end
                else
                begin
                    pay_left = pay_left - 1;
                end
            end
            default:
            begin
                pred_major = b[7:5];
                pred_phase = PH_IDLE;
                arg_acc    = '0;
                arg_left   = '0;
                if (ai <= AI_DIRECT_MAX)
                begin
                    finish_head({59'd0, ai});
                end
                else if (ai <= AI_EIGHT_BYTE)
                begin
                    arg_left   = 4'd1 << (ai - AI_ONE_BYTE);
                    pred_phase = PH_ARG;
                end
                else
                begin
                    push_token(KIND_ERROR, pred_major, '0, '0, 1'b0);
                end
            end
        endcase
    endtask

    // Called at a falling edge; returns at the falling edge after the request
    // was accepted, with the prediction already updated.
    task send_byte(input logic [7:0] b);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        decode_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    // nbytes is 0 for an argument carried in the additional info, else 1, 2, 4 or 8.
    task send_head(input logic [2:0] major, input int nbytes, input logic [63:0] arg);
        logic [4:0] ai;
        case (nbytes)
            0:       ai = arg[4:0];
            1:       ai = AI_ONE_BYTE;
            2:       ai = AI_TWO_BYTE;
            4:       ai = AI_FOUR_BYTE;
            default: ai = AI_EIGHT_BYTE;
        endcase
        send_byte(head_byte(major, ai));
        for (int i = nbytes - 1; i >= 0; i--)
        begin
            send_byte(arg[8 * i +: 8]);
        end
    endtask

    task send_string(input logic [2:0] major, input int nbytes, input int len);
        send_head(major, nbytes, 64'(len));
        repeat (len) send_byte(8'($urandom_range(0, 255)));
    endtask

    // Sender idles until every predicted token has come out, then lets the
    // pipeline settle.
    task wait_for_tokens();
        s_axis_tvalid <= 1'b0;
        while (expected_tokens.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // One well-formed item with random content, or now and then a stray byte.
    // Stray bytes never open a string with a two- to eight-byte length, and
    // after one the stream is filled with random bytes until the decoder is
    // idle again, so string payloads always stay short.
    task send_random_item();
        int          r;
        int          w;
        int          nbytes;
        int          len;
        logic [2:0]  major;
        logic [7:0]  b;
        logic [63:0] arg;
        r = $urandom_range(0, 99);
        w = $urandom_range(0, 4);
        nbytes = (w == 0) ? 0 : (1 << (w - 1));
        major = 3'($urandom_range(0, 7));
        if (pred_phase != PH_IDLE)
        begin
            send_byte(8'($urandom_range(0, 255)));
        end
        else if (r < 8)
        begin
            b = 8'($urandom_range(0, 255));
            if ((b[7:5] == MAJ_BYTES || b[7:5] == MAJ_TEXT) && b[4:0] > AI_ONE_BYTE &&
                b[4:0] <= AI_EIGHT_BYTE)
            begin
                b[4:0] = AI_ONE_BYTE;
            end
            send_byte(b);
        end
        else if (r < 14)
        begin
            send_byte(head_byte(major, 5'($urandom_range(AI_RSVD_FIRST, AI_INDEF))));
        end
        else if (major == MAJ_BYTES || major == MAJ_TEXT)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 60) : $urandom_range(0, 8);
            if (nbytes == 0 && len > AI_DIRECT_MAX)
            begin
                nbytes = 1;
            end
            send_string(major, nbytes, len);
        end
        else
        begin
            case (nbytes)
                0:       arg = $urandom_range(0, AI_DIRECT_MAX);
                1:       arg = $urandom_range(0, 255);
                2:       arg = $urandom_range(0, 65535);
                4:       arg = $urandom;
                default: arg = {$urandom, $urandom};
            endcase
            r = $urandom_range(0, 19);
            if (r == 0)
            begin
                arg = '0;
            end
            else if (r == 1)
            begin
                arg = (nbytes == 0) ? AI_DIRECT_MAX : ~64'd0 >> (64 - 8 * nbytes);
            end
            send_head(major, nbytes, arg);
        end
    endtask

    // Integer, tag, container and simple heads at the edges of each width.
    task test_integer_heads();
        send_head(MAJ_UINT, 0, 0);
        send_head(MAJ_UINT, 0, AI_DIRECT_MAX);
        send_head(MAJ_UINT, 1, 64'hFF);
        send_head(MAJ_UINT, 2, 64'hFFFF);
        send_head(MAJ_UINT, 4, 64'hFFFF_FFFF);
        send_head(MAJ_UINT, 8, ~64'd0);
        send_head(MAJ_UINT, 8, 64'd0);
        send_head(MAJ_NEGINT, 0, 0);
        send_head(MAJ_NEGINT, 8, ~64'd0);
        send_head(MAJ_NEGINT, 1, 64'h80);
        // A tag is only a head; the tagged item follows as a normal item.
        send_head(MAJ_TAG, 4, 64'h8000_0001);
        send_head(MAJ_UINT, 2, 64'h1234);
        send_head(MAJ_ARRAY, 0, AI_DIRECT_MAX);
        send_head(MAJ_MAP, 1, 64'h01);
        send_head(MAJ_SIMPLE, 1, 64'hFF);
        send_head(MAJ_SIMPLE, 2, 64'h7C00);
        send_head(MAJ_SIMPLE, 8, 64'hA5A5_5A5A_0F0F_F0F0);
        wait_for_tokens();
    endtask

    // Empty and short strings, a payload that looks like heads, a string
    // longer than one byte of length, and every reserved additional info.
    task test_strings_and_errors();
        send_head(MAJ_BYTES, 0, 0);
        send_head(MAJ_TEXT, 8, 0);
        send_head(MAJ_TEXT, 0, 1);
        send_byte(8'hFF);
        send_head(MAJ_BYTES, 1, 3);
        send_byte(head_byte(MAJ_BYTES, AI_INDEF));
        send_byte(head_byte(MAJ_TEXT, AI_EIGHT_BYTE));
        send_byte(8'h00);
        send_string(MAJ_TEXT, 2, 300);
        send_byte(head_byte(MAJ_UINT, AI_RSVD_FIRST));
        send_byte(head_byte(MAJ_BYTES, AI_RSVD_MID1));
        send_byte(head_byte(MAJ_MAP, AI_RSVD_MID2));
        send_byte(head_byte(MAJ_SIMPLE, AI_INDEF));
        send_head(MAJ_UINT, 0, 5);
        wait_for_tokens();
    endtask

    // Full rate on both sides.
    task test_back_to_back();
        no_idle = 1'b1;
        repeat (60) send_random_item();
        wait_for_tokens();
        no_idle = 1'b0;
    endtask

    // Random stream with idling on both sides and one full drain halfway.
    task test_random_stream();
        int  start;
        bit  paused;
        start  = bytes_sent;
        paused = 1'b0;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            send_random_item();
            if (!paused && bytes_sent - start >= RANDOM_BYTES / 2)
            begin
                wait_for_tokens();
                paused = 1'b1;
            end
        end
        wait_for_tokens();
    endtask

    // Receiver: ready most cycles, with random stalls.
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold       <= rx_hold - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            rx_hold       <= gap_len();
        end
    end

    // Every accepted token is checked against the oldest prediction.
    always @(posedge clk)
    begin : check_tokens
        cbd_token_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_tokens.size() == 0)
            begin
                report_mismatch("token with none predicted", '0, m_axis_tdata[66:3]);
            end
            else
            begin
                want = expected_tokens.pop_front();
                compare_field("kind", want.kind, m_axis_tuser);
                compare_field("major_type", want.major_type, m_axis_tdata[2:0]);
                compare_field("value", want.value, m_axis_tdata[66:3]);
                compare_field("payload_byte", want.payload_byte, m_axis_tdata[74:67]);
                compare_field("tdata padding", '0, m_axis_tdata[79:75]);
                compare_field("last_payload", want.last_payload, m_axis_tlast);
                case (want.kind)
                    KIND_HEAD:    heads_seen++;
                    KIND_PAYLOAD: payloads_seen++;
                    default:      errors_seen++;
                endcase
            end
            tokens_checked++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_integer_heads();
        test_strings_and_errors();
        test_back_to_back();
        test_random_stream();
        $display("%0d bytes sent; %0d heads, %0d payload bytes, %0d error tokens checked",
                 bytes_sent, heads_seen, payloads_seen, errors_seen);
        $display("heads of all major types and widths, strings up to 300 bytes, stalls");
        if (error_count == 0 && expected_tokens.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("%0d mismatches, %0d tokens never seen", error_count,
                     expected_tokens.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule
